/* sv/tcpq_pkg.sv */
// shared types and constants for the two-class priority task queue
// no dependencies; used by every module of the block
package tcpq_pkg;

  localparam int DEPTH        = 64;
  localparam int PAYLOAD_BITS = 32;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int ADDR_W       = 4;

  typedef enum logic [2:0] {
    REQ_ENQ    = 3'd0,
    REQ_DEQ    = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_DUP      = 3'd3,
    ST_CLOSED   = 3'd4
  } stat_t;

  typedef enum logic [1:0] {
    REG_SIZE_LIMIT = 2'd0,
    REG_DUP_OK     = 2'd1,
    REG_CLOSED     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] task_id;
    logic        high_priority;
    logic [31:0] task_payload;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_task_id;
    logic [31:0] out_payload;
    logic        out_high;
    logic [6:0]  task_count;
    logic [6:0]  high_count;
    logic [63:0] enqueued_total;
    logic [63:0] dequeued_total;
    logic [6:0]  cleared_count;
  } rsp_t;

  typedef struct packed {
    logic [6:0] size_limit;
    logic       duplicates_allowed;
    logic       queue_closed;
  } cfg_t;

  typedef struct packed {
    logic [63:0]             id;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    cls;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_HEAD,
    S_INS_CHK,
    S_INS_WR,
    S_CLS_CHK,
    S_CLS_WR,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_ZERO, IDX_INC, IDX_DEC, IDX_CNT
  } idx_op_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_IDX, RD_IDX_INC, RD_IDX_DEC, RD_ZERO
  } rd_op_t;

  typedef enum logic [1:0] {
    WR_NONE, WR_RDATA, WR_NEW
  } wr_op_t;

  typedef enum logic [1:0] {
    CM_NONE, CM_ENQ, CM_CLOSE, CM_CLEAR
  } commit_t;

  typedef struct packed {
    logic    accept;
    idx_op_t idx_op;
    rd_op_t  rd_op;
    wr_op_t  wr_op;
    logic    cap_head;
    logic    cap_victim;
    logic    set_status;
    stat_t   status;
    commit_t commit;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       closed;
    logic       full;
    logic       dup_allowed;
    logic       cnt_zero;
    logic       id_match;
    logic       idx_next_is_cnt;
    logic       at_ins_pos;
    logic       out_free;
  } sts_t;

endpackage

/* sv/tcpq_regs.sv */
// configuration registers behind the apb-style port
// depends on tcpq_pkg
module tcpq_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tcpq_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output tcpq_pkg::cfg_t               cfg
);

  tcpq_pkg::reg_idx_t sel;

  assign pready = 1'b1;
  assign sel    = tcpq_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_limit         <= 7'(tcpq_pkg::DEPTH);
      cfg.duplicates_allowed <= 1'b1;
      cfg.queue_closed       <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        tcpq_pkg::REG_SIZE_LIMIT: cfg.size_limit         <= pwdata[6:0];
        tcpq_pkg::REG_DUP_OK:     cfg.duplicates_allowed <= pwdata[0];
        tcpq_pkg::REG_CLOSED:     cfg.queue_closed       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      tcpq_pkg::REG_SIZE_LIMIT: prdata = {25'd0, cfg.size_limit};
      tcpq_pkg::REG_DUP_OK:     prdata = {31'd0, cfg.duplicates_allowed};
      tcpq_pkg::REG_CLOSED:     prdata = {31'd0, cfg.queue_closed};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

/* sv/tcpq_ctrl.sv */
// sequencer for the task queue: decodes a request and steps the datapath
// depends on tcpq_pkg
module tcpq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  tcpq_pkg::sts_t sts,
  output tcpq_pkg::cmd_t cmd
);

  tcpq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcpq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != tcpq_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      tcpq_pkg::S_IDLE: if (req_valid) state_next = tcpq_pkg::S_DECODE;
      tcpq_pkg::S_DECODE: begin
        case (sts.req_type)
          tcpq_pkg::REQ_ENQ: begin
            if (sts.closed || sts.full) state_next = tcpq_pkg::S_OUT;
            else if (!sts.dup_allowed && !sts.cnt_zero) state_next = tcpq_pkg::S_SRCH_RD;
            else state_next = tcpq_pkg::S_INS_CHK;
          end
          tcpq_pkg::REQ_DEQ, tcpq_pkg::REQ_PEEK:
            state_next = sts.cnt_zero ? tcpq_pkg::S_OUT : tcpq_pkg::S_HEAD;
          tcpq_pkg::REQ_REMOVE:
            state_next = sts.cnt_zero ? tcpq_pkg::S_OUT : tcpq_pkg::S_SRCH_RD;
          default: state_next = tcpq_pkg::S_OUT;
        endcase
      end
      tcpq_pkg::S_SRCH_RD: state_next = tcpq_pkg::S_SRCH_CMP;
      tcpq_pkg::S_SRCH_CMP: begin
        if (sts.id_match) begin
          state_next = (sts.req_type == tcpq_pkg::REQ_ENQ) ? tcpq_pkg::S_OUT
                                                           : tcpq_pkg::S_CLS_CHK;
        end else if (sts.idx_next_is_cnt) begin
          state_next = (sts.req_type == tcpq_pkg::REQ_ENQ) ? tcpq_pkg::S_INS_CHK
                                                           : tcpq_pkg::S_OUT;
        end else begin
          state_next = tcpq_pkg::S_SRCH_RD;
        end
      end
      tcpq_pkg::S_HEAD:
        state_next = (sts.req_type == tcpq_pkg::REQ_DEQ) ? tcpq_pkg::S_CLS_CHK
                                                         : tcpq_pkg::S_OUT;
      tcpq_pkg::S_INS_CHK:
        state_next = sts.at_ins_pos ? tcpq_pkg::S_OUT : tcpq_pkg::S_INS_WR;
      tcpq_pkg::S_INS_WR: state_next = tcpq_pkg::S_INS_CHK;
      tcpq_pkg::S_CLS_CHK:
        state_next = sts.idx_next_is_cnt ? tcpq_pkg::S_OUT : tcpq_pkg::S_CLS_WR;
      tcpq_pkg::S_CLS_WR: state_next = tcpq_pkg::S_CLS_CHK;
      tcpq_pkg::S_OUT: if (sts.out_free) state_next = tcpq_pkg::S_IDLE;
      default: state_next = tcpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.idx_op     = tcpq_pkg::IDX_HOLD;
    cmd.rd_op      = tcpq_pkg::RD_NONE;
    cmd.wr_op      = tcpq_pkg::WR_NONE;
    cmd.status     = tcpq_pkg::ST_OK;
    cmd.commit     = tcpq_pkg::CM_NONE;
    unique case (state)
      tcpq_pkg::S_IDLE: cmd.accept = req_valid;
      tcpq_pkg::S_DECODE: begin
        case (sts.req_type)
          tcpq_pkg::REQ_ENQ: begin
            cmd.set_status = sts.closed || sts.full;
            cmd.status     = sts.closed ? tcpq_pkg::ST_CLOSED : tcpq_pkg::ST_FULL;
            cmd.idx_op     = (!sts.dup_allowed && !sts.cnt_zero) ? tcpq_pkg::IDX_ZERO
                                                                 : tcpq_pkg::IDX_CNT;
          end
          tcpq_pkg::REQ_DEQ, tcpq_pkg::REQ_PEEK, tcpq_pkg::REQ_REMOVE: begin
            cmd.set_status = sts.cnt_zero;
            cmd.status     = tcpq_pkg::ST_EMPTY;
            cmd.idx_op     = tcpq_pkg::IDX_ZERO;
            cmd.rd_op      = tcpq_pkg::RD_ZERO;
          end
          tcpq_pkg::REQ_CLEAR: cmd.commit = tcpq_pkg::CM_CLEAR;
          default: ;
        endcase
      end
      tcpq_pkg::S_SRCH_RD: cmd.rd_op = tcpq_pkg::RD_IDX;
      tcpq_pkg::S_SRCH_CMP: begin
        cmd.cap_victim = 1'b1;
        if (sts.id_match) begin
          cmd.set_status = (sts.req_type == tcpq_pkg::REQ_ENQ);
          cmd.status     = tcpq_pkg::ST_DUP;
        end else if (sts.idx_next_is_cnt) begin
          cmd.set_status = (sts.req_type != tcpq_pkg::REQ_ENQ);
          cmd.status     = tcpq_pkg::ST_EMPTY;
          cmd.idx_op     = tcpq_pkg::IDX_CNT;
        end else begin
          cmd.idx_op = tcpq_pkg::IDX_INC;
        end
      end
      tcpq_pkg::S_HEAD: begin
        cmd.cap_head   = 1'b1;
        cmd.cap_victim = 1'b1;
      end
      tcpq_pkg::S_INS_CHK: begin
        if (sts.at_ins_pos) begin
          cmd.wr_op  = tcpq_pkg::WR_NEW;
          cmd.commit = tcpq_pkg::CM_ENQ;
        end else begin
          cmd.rd_op = tcpq_pkg::RD_IDX_DEC;
        end
      end
      tcpq_pkg::S_INS_WR: begin
        cmd.wr_op  = tcpq_pkg::WR_RDATA;
        cmd.idx_op = tcpq_pkg::IDX_DEC;
      end
      tcpq_pkg::S_CLS_CHK: begin
        if (sts.idx_next_is_cnt) cmd.commit = tcpq_pkg::CM_CLOSE;
        else cmd.rd_op = tcpq_pkg::RD_IDX_INC;
      end
      tcpq_pkg::S_CLS_WR: begin
        cmd.wr_op  = tcpq_pkg::WR_RDATA;
        cmd.idx_op = tcpq_pkg::IDX_INC;
      end
      tcpq_pkg::S_OUT: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

/* sv/tcpq_dp.sv */
// datapath: position-ordered entry memory, walk index, counters, result register
// depends on tcpq_pkg
module tcpq_dp (
  input  logic           clk,
  input  logic           rst,
  input  tcpq_pkg::req_t req_data,
  input  tcpq_pkg::cfg_t cfg,
  input  tcpq_pkg::cmd_t cmd,
  output tcpq_pkg::sts_t sts,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tcpq_pkg::rsp_t rsp_data
);

  localparam int IW = tcpq_pkg::IDX_W;
  localparam int CW = tcpq_pkg::CNT_W;

  tcpq_pkg::entry_t mem [tcpq_pkg::DEPTH];
  tcpq_pkg::entry_t rdata, head, new_entry;
  tcpq_pkg::req_t   req;
  logic [CW-1:0]    cnt, hcnt, idx, cleared, lim, ins_pos, idx_inc, idx_dec;
  logic [63:0]      enq_tot, deq_tot;
  logic [2:0]       status;
  logic             victim;
  logic [IW-1:0]    raddr;

  assign idx_inc = idx + CW'(1);
  assign idx_dec = idx - CW'(1);
  assign lim     = (cfg.size_limit == 7'd0 || cfg.size_limit > 7'(tcpq_pkg::DEPTH))
                   ? CW'(tcpq_pkg::DEPTH) : CW'(cfg.size_limit);
  // high tasks always form the leading run, so they end at hcnt
  assign ins_pos = req.high_priority ? hcnt : cnt;

  assign new_entry.id      = req.task_id;
  assign new_entry.payload = req.task_payload[tcpq_pkg::PAYLOAD_BITS-1:0];
  assign new_entry.cls     = req.high_priority;

  always_comb begin
    case (cmd.rd_op)
      tcpq_pkg::RD_IDX_INC: raddr = idx_inc[IW-1:0];
      tcpq_pkg::RD_IDX_DEC: raddr = idx_dec[IW-1:0];
      tcpq_pkg::RD_ZERO:    raddr = '0;
      default:              raddr = idx[IW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_op != tcpq_pkg::RD_NONE) rdata <= mem[raddr];
    if (cmd.wr_op == tcpq_pkg::WR_RDATA) mem[idx[IW-1:0]] <= rdata;
    else if (cmd.wr_op == tcpq_pkg::WR_NEW) mem[idx[IW-1:0]] <= new_entry;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) req <= req_data;
    case (cmd.idx_op)
      tcpq_pkg::IDX_ZERO: idx <= '0;
      tcpq_pkg::IDX_INC:  idx <= idx_inc;
      tcpq_pkg::IDX_DEC:  idx <= idx_dec;
      tcpq_pkg::IDX_CNT:  idx <= cnt;
      default: ;
    endcase
    if (cmd.cap_victim) victim <= rdata.cls;
    if (cmd.accept) head <= '0;
    else if (cmd.cap_head) head <= rdata;
    if (cmd.accept) status <= tcpq_pkg::ST_OK;
    else if (cmd.set_status) status <= cmd.status;
    if (cmd.accept) cleared <= '0;
    else if (cmd.commit == tcpq_pkg::CM_CLEAR) cleared <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      hcnt    <= '0;
      enq_tot <= '0;
      deq_tot <= '0;
    end else begin
      case (cmd.commit)
        tcpq_pkg::CM_ENQ: begin
          cnt     <= cnt + CW'(1);
          enq_tot <= enq_tot + 64'd1;
          if (req.high_priority) hcnt <= hcnt + CW'(1);
        end
        tcpq_pkg::CM_CLOSE: begin
          cnt <= cnt - CW'(1);
          if (victim && hcnt != '0) hcnt <= hcnt - CW'(1);
          if (req.req_type == tcpq_pkg::REQ_DEQ) deq_tot <= deq_tot + 64'd1;
        end
        tcpq_pkg::CM_CLEAR: begin
          cnt  <= '0;
          hcnt <= '0;
        end
        default: ;
      endcase
    end
  end

  // result register frees when its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_data.status         <= status;
      rsp_data.out_task_id    <= head.id;
      rsp_data.out_payload    <= 32'(head.payload);
      rsp_data.out_high       <= head.cls;
      rsp_data.task_count     <= 7'(cnt);
      rsp_data.high_count     <= 7'(hcnt);
      rsp_data.enqueued_total <= enq_tot;
      rsp_data.dequeued_total <= deq_tot;
      rsp_data.cleared_count  <= 7'(cleared);
    end
  end

  assign sts.req_type        = req.req_type;
  assign sts.closed          = cfg.queue_closed;
  assign sts.full            = (cnt >= lim);
  assign sts.dup_allowed     = cfg.duplicates_allowed;
  assign sts.cnt_zero        = (cnt == '0);
  assign sts.id_match        = (rdata.id == req.task_id);
  assign sts.idx_next_is_cnt = (idx_inc == cnt);
  assign sts.at_ins_pos      = (idx == ins_pos);
  assign sts.out_free        = !rsp_valid || !rsp_stall;

endmodule

/* sv/two_class_priority_task_queue_core.sv */
// two-class priority task queue, top level
// an id search walks the entries from the head, and an insert or a removal shifts
//   the entries behind it one position at a time
// requests: one at a time; req_stall is high from acceptance until the result is loaded
// reset: synchronous; empties the queue, zeroes totals, restores config defaults
module two_class_priority_task_queue_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  tcpq_pkg::req_t              req_data,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output tcpq_pkg::rsp_t              rsp_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcpq_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  tcpq_pkg::cfg_t cfg;
  tcpq_pkg::cmd_t cmd;
  tcpq_pkg::sts_t sts;

  tcpq_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  tcpq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .sts(sts), .cmd(cmd)
  );

  tcpq_dp u_dp (
    .clk(clk), .rst(rst), .req_data(req_data), .cfg(cfg), .cmd(cmd), .sts(sts),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
  );

endmodule

/* tb/sv/tb_two_class_priority_task_queue_core.sv */
// testbench for the two-class priority task queue core
// depends on tcpq_pkg and two_class_priority_task_queue_core
`timescale 1ns / 100ps

module tb_two_class_priority_task_queue_core;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_stall;
  tcpq_pkg::req_t              req_data = '0;
  logic                        rsp_valid;
  logic                        rsp_stall = 1'b0;
  tcpq_pkg::rsp_t              rsp_data;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [tcpq_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  // mirror of the queue contents, index 0 is the head
  logic [63:0] q_ids[$];
  logic [31:0] q_pay[$];
  logic        q_cls[$];
  int          q_high;
  logic [63:0] enq_total, deq_total;
  logic [6:0]  lim_reg;
  logic        dup_ok, closed;

  tcpq_pkg::rsp_t rsp_expected[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          rsp_seen = 0;
  int          rsp_wait = 0;
  bit          hold_rsp = 1'b0;
  bit          random_rsp_gaps = 1'b1;

  two_class_priority_task_queue_core DUT (.*);

  always #5 clk = ~clk;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    errors++;
    $display("mismatch %s: got %0h expected %0h (response %0d)", what, got, exp, rsp_seen);
  endtask

  function automatic int find_pos(input logic [63:0] id);
    for (int i = 0; i < q_ids.size(); i++) if (q_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_at(input int p);
    if (q_cls[p]) q_high--;
    q_ids.delete(p); q_pay.delete(p); q_cls.delete(p);
  endfunction

  // queue behavior model; appends the expected response
  function automatic void predict_queue(input tcpq_pkg::req_t r);
    tcpq_pkg::rsp_t e;
    int   p, lim;
    e = '0;
    lim = (lim_reg == 7'd0 || int'(lim_reg) > tcpq_pkg::DEPTH) ? tcpq_pkg::DEPTH
                                                               : int'(lim_reg);
    case (r.req_type)
      tcpq_pkg::REQ_ENQ: begin
        if (closed) e.status = tcpq_pkg::ST_CLOSED;
        else if (q_ids.size() >= lim) e.status = tcpq_pkg::ST_FULL;
        else if (!dup_ok && find_pos(r.task_id) >= 0) e.status = tcpq_pkg::ST_DUP;
        else begin
          if (r.high_priority) begin
            p = 0;
            while (p < q_ids.size() && q_cls[p]) p++;
            q_high++;
          end else begin
            p = q_ids.size();
          end
          q_ids.insert(p, r.task_id);
          q_pay.insert(p, r.task_payload);
          q_cls.insert(p, r.high_priority);
          enq_total++;
        end
      end
      tcpq_pkg::REQ_DEQ, tcpq_pkg::REQ_PEEK: begin
        if (q_ids.size() == 0) e.status = tcpq_pkg::ST_EMPTY;
        else begin
          e.out_task_id = q_ids[0];
          e.out_payload = q_pay[0];
          e.out_high = q_cls[0];
          if (r.req_type == tcpq_pkg::REQ_DEQ) begin
            drop_at(0);
            deq_total++;
          end
        end
      end
      tcpq_pkg::REQ_REMOVE: begin
        p = find_pos(r.task_id);
        if (p >= 0) drop_at(p);
        else e.status = tcpq_pkg::ST_EMPTY;
      end
      tcpq_pkg::REQ_CLEAR: begin
        e.cleared_count = 7'(q_ids.size());
        q_ids.delete(); q_pay.delete(); q_cls.delete();
        q_high = 0;
      end
      default: ;
    endcase
    e.task_count = 7'(q_ids.size());
    e.high_count = 7'(q_high);
    e.enqueued_total = enq_total;
    e.dequeued_total = deq_total;
    rsp_expected.push_back(e);
  endfunction

  // valid stays up into the next item when there is no gap
  task automatic send_req(input tcpq_pkg::req_t r, input bit gaps = 1'b1);
    int waits;
    waits = gaps ? $urandom_range(0, 10) : 0;
    if ($urandom_range(0, 3) == 0) waits = 0;
    if (waits > 0) begin
      req_valid <= 1'b0;
      repeat (waits) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_queue(r);
  endtask

  task automatic write_reg(input tcpq_pkg::reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= tcpq_pkg::ADDR_W'(4 * int'(idx)); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      tcpq_pkg::REG_SIZE_LIMIT: lim_reg = val[6:0];
      tcpq_pkg::REG_DUP_OK:     dup_ok = val[0];
      tcpq_pkg::REG_CLOSED:     closed = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drain, then a latency margin before touching configuration
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (rsp_expected.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_config(input logic [6:0] lim, input logic dup, input logic cls);
    wait_idle();
    write_reg(tcpq_pkg::REG_SIZE_LIMIT, {25'd0, lim});
    write_reg(tcpq_pkg::REG_DUP_OK, {31'd0, dup});
    write_reg(tcpq_pkg::REG_CLOSED, {31'd0, cls});
  endtask

  function automatic tcpq_pkg::req_t mk(input logic [2:0] k, input logic [63:0] id,
                                        input logic hi, input logic [31:0] pay);
    tcpq_pkg::req_t r;
    r.req_type = k; r.task_id = id; r.high_priority = hi; r.task_payload = pay;
    return r;
  endfunction

  function automatic tcpq_pkg::req_t rand_req(input int id_span);
    tcpq_pkg::req_t r;
    int   sel;
    sel = $urandom_range(0, 99);
    r.req_type = sel < 45 ? tcpq_pkg::REQ_ENQ : sel < 65 ? tcpq_pkg::REQ_DEQ :
                 sel < 77 ? tcpq_pkg::REQ_PEEK : sel < 93 ? tcpq_pkg::REQ_REMOVE :
                 sel < 96 ? tcpq_pkg::REQ_CLEAR : 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) == 0) r.task_id = {$urandom, $urandom};
    else r.task_id = 64'($urandom_range(0, id_span));
    r.high_priority = 1'($urandom_range(0, 1));
    r.task_payload = $urandom;
    return r;
  endfunction

  task automatic test_directed();
    send_req(mk(tcpq_pkg::REQ_DEQ, 0, 0, 0));
    send_req(mk(tcpq_pkg::REQ_PEEK, 0, 0, 0));
    send_req(mk(tcpq_pkg::REQ_CLEAR, 0, 0, 0));
    send_req(mk(tcpq_pkg::REQ_REMOVE, 64'd5, 0, 0));
    send_req(mk(tcpq_pkg::REQ_ENQ, 64'd1, 0, 32'hFFFF_FFFF));
    send_req(mk(tcpq_pkg::REQ_ENQ, 64'hFFFF_FFFF_FFFF_FFFF, 1, 32'h0));
    send_req(mk(tcpq_pkg::REQ_ENQ, 64'd2, 1, 32'h1234_5678));
    send_req(mk(tcpq_pkg::REQ_ENQ, 64'd1, 0, 32'hA5A5_A5A5));
    send_req(mk(tcpq_pkg::REQ_PEEK, 0, 0, 0));
    send_req(mk(3'd5, 64'd1, 1, 32'hFFFF_FFFF));
    send_req(mk(3'd7, 0, 0, 0));
    send_req(mk(tcpq_pkg::REQ_REMOVE, 64'd1, 0, 0));
    send_req(mk(tcpq_pkg::REQ_DEQ, 0, 0, 0));
    send_req(mk(tcpq_pkg::REQ_REMOVE, 64'd99, 0, 0));
    send_req(mk(tcpq_pkg::REQ_CLEAR, 0, 0, 0));
  endtask

  task automatic test_config_rules();
    set_config(7'd2, 1'b0, 1'b0);
    send_req(mk(tcpq_pkg::REQ_ENQ, 64'd7, 0, 32'd1));
    send_req(mk(tcpq_pkg::REQ_ENQ, 64'd7, 1, 32'd2));   // duplicate
    send_req(mk(tcpq_pkg::REQ_ENQ, 64'd8, 1, 32'd3));
    send_req(mk(tcpq_pkg::REQ_ENQ, 64'd9, 0, 32'd4));   // full
    set_config(7'd2, 1'b0, 1'b1);
    send_req(mk(tcpq_pkg::REQ_ENQ, 64'd7, 0, 32'd5));   // closed wins over full and duplicate
    set_config(7'd0, 1'b1, 1'b0);
    send_req(mk(tcpq_pkg::REQ_CLEAR, 0, 0, 0));
  endtask

  task automatic test_fill_limits();
    // limit above capacity means full depth
    set_config(7'd127, 1'b1, 1'b0);
    for (int i = 0; i < tcpq_pkg::DEPTH + 2; i++)
      send_req(mk(tcpq_pkg::REQ_ENQ, 64'($urandom_range(0, 20)),
                  1'($urandom_range(0, 1)), $urandom), 1'b0);
    send_req(mk(tcpq_pkg::REQ_CLEAR, 0, 0, 0));
    set_config(7'd64, 1'b1, 1'b0);
  endtask

  task automatic test_backpressure();
    wait_idle();
    random_rsp_gaps = 1'b0;
    hold_rsp = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_rsp = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_req(rand_req(8), 1'b0);
    join
    random_rsp_gaps = 1'b1;
  endtask

  task automatic test_random(input int n, input int id_span);
    for (int i = 0; i < n; i++) send_req(rand_req(id_span));
  endtask

  task automatic test_random_configs();
    logic [6:0] lims[4] = '{7'd1, 7'd5, 7'd0, 7'd64};
    for (int k = 0; k < 4; k++) begin
      set_config(lims[k], k[0], 1'b0);
      test_random(150, 12);
    end
    set_config(7'd64, 1'b0, 1'b1);
    test_random(30, 12);
    set_config(7'd64, 1'b1, 1'b0);
    test_random(250, 40);
  endtask

  // response side: a drawn wait before each transfer plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      rsp_wait = 0;
    end else if (hold_rsp) begin
      rsp_stall <= 1'b1;
    end else if (!random_rsp_gaps) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_wait = $urandom_range(0, 10);
      if (rsp_wait > 0) begin
        rsp_stall <= 1'b1;
        rsp_wait--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    tcpq_pkg::rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_seen++;
      if (rsp_expected.size() == 0) begin
        report("unexpected response", 64'(rsp_data.status), 64'd0);
      end else begin
        e = rsp_expected.pop_front();
        if (rsp_data.status != e.status)
          report("status", 64'(rsp_data.status), 64'(e.status));
        if (rsp_data.out_task_id != e.out_task_id)
          report("out_task_id", rsp_data.out_task_id, e.out_task_id);
        if (rsp_data.out_payload != e.out_payload)
          report("out_payload", 64'(rsp_data.out_payload), 64'(e.out_payload));
        if (rsp_data.out_high != e.out_high)
          report("out_high", 64'(rsp_data.out_high), 64'(e.out_high));
        if (rsp_data.task_count != e.task_count)
          report("task_count", 64'(rsp_data.task_count), 64'(e.task_count));
        if (rsp_data.high_count != e.high_count)
          report("high_count", 64'(rsp_data.high_count), 64'(e.high_count));
        if (rsp_data.enqueued_total != e.enqueued_total)
          report("enqueued_total", rsp_data.enqueued_total, e.enqueued_total);
        if (rsp_data.dequeued_total != e.dequeued_total)
          report("dequeued_total", rsp_data.dequeued_total, e.dequeued_total);
        if (rsp_data.cleared_count != e.cleared_count)
          report("cleared_count", 64'(rsp_data.cleared_count), 64'(e.cleared_count));
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("two_class_priority_task_queue_core verification failed");
      $finish;
    end
  end

  initial begin
    q_high = 0; enq_total = 0; deq_total = 0;
    lim_reg = 7'd64; dup_ok = 1'b1; closed = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_rules();
    test_fill_limits();
    test_backpressure();
    test_random_configs();
    wait_idle();
    $display("covered all request kinds, limits 0 to 127, duplicate and closed rules,");
    $display("full-queue backpressure; %0d responses checked", rsp_seen);
    if (errors == 0) begin
      $display("two_class_priority_task_queue_core verification clean");
    end else begin
      $display("two_class_priority_task_queue_core verification failed");
    end
    $finish;
  end

endmodule
